FILE: sv/alu_8_16_bit_with_bcd_macros.svh
// ----------------------------------------------------------------------------
// ALU assertion macros
// Shared concurrent assertion forms for the ALU checker.
// ----------------------------------------------------------------------------
`ifndef ALU_8_16_BIT_WITH_BCD_MACROS_SVH
`define ALU_8_16_BIT_WITH_BCD_MACROS_SVH

// Checked on every clock edge outside reset.
`define ALUBCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ALUBCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/alubcd_pkg.sv
// ----------------------------------------------------------------------------
// ALU package
// Opcodes, stream field layout and result types of the 8/16-bit BCD ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alubcd_pkg;

  typedef enum logic [2:0] {
    OP_ASL = 3'd0,
    OP_LSR = 3'd1,
    OP_ROL = 3'd2,
    OP_ROR = 3'd3,
    OP_ADC = 3'd4,
    OP_SBC = 3'd5,
    OP_BIT = 3'd6,
    OP_CMP = 3'd7
  } op_e;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned DIGITS   = WORD_W / DIGIT_W;

  // slave-side layout
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_A_LSB   = 0;
  localparam int unsigned IN_B_LSB   = 16;
  localparam int unsigned IN_C_BIT   = 32;
  localparam int unsigned IN_V_BIT   = 33;
  localparam int unsigned IN_D_BIT   = 34;
  localparam int unsigned IN_OP_LSB  = 0;
  localparam int unsigned IN_WIDE_BIT = 3;

  // master-side layout
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_RES_LSB = 0;
  localparam int unsigned OUT_C_BIT  = 16;
  localparam int unsigned OUT_V_BIT  = 17;
  localparam int unsigned OUT_Z_BIT  = 18;
  localparam int unsigned OUT_N_BIT  = 19;

  // BCD digit correction
  localparam logic [5:0] BCD_ADJ  = 6'h06;
  localparam logic [4:0] BCD_MAX  = 5'h09;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic              cout;
    logic              vout;
  } add_res_t;

endpackage

FILE: sv/alu_8_16_bit_with_bcd.sv
// ----------------------------------------------------------------------------
// 8/16-bit accumulator ALU with BCD
// Shifts, rotates, binary or packed-BCD add/subtract, BIT and CMP, with flags.
// ----------------------------------------------------------------------------
// One operation enters per transfer on the slave side and leaves as one
// result transfer on the master side. The block sustains one transfer per
// clock cycle while the master side is ready. Each operation passes the
// input register, then the result register, with the whole ALU evaluated
// in the one combinational pass between them - the four-digit BCD carry
// chain is the longest path. Backpressure stalls the result register, and
// the input register too once it holds an operation. In 8-bit mode the
// upper operand bytes are ignored and the result's upper byte is zero. BIT
// returns the AND of its operands; its negative flag reads 0 and the caller
// keeps its old N.
`timescale 1ns / 1ps

module alu_8_16_bit_with_bcd (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] first_operand, [31:16] second_operand, [32] carry_in,
  // [33] overflow_in, [34] decimal_in, [39:35] zero
  input  logic [alubcd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] opcode, [3] wide
  input  logic [alubcd_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] result, [16] carry_out, [17] overflow_out, [18] zero_out,
  // [19] negative_out, [23:20] zero
  output logic [alubcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import alubcd_pkg::*;

  // Binary or BCD add of a, b (already inverted for subtract) and carry.
  function automatic add_res_t add_core(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b,
                                        input logic c_in,
                                        input logic dec,
                                        input logic sub,
                                        input logic wide);
    add_res_t              r;
    logic [WORD_W:0]       bin;
    logic [WORD_W-1:0]     raw;
    logic [WORD_W-1:0]     res;
    logic                  c;
    logic [4:0]            s;
    logic [5:0]            adj;
    logic [DIGIT_W-1:0]    top_s;
    logic                  sign_v;
    r     = '0;
    res   = '0;
    c     = c_in;
    top_s = '0;
    if (!dec) begin
      bin    = {1'b0, a} + {1'b0, b} + {{WORD_W{1'b0}}, c_in};
      res    = wide ? bin[WORD_W-1:0] : {8'h00, bin[7:0]};
      c      = wide ? bin[WORD_W] : bin[8];
      raw    = res;
    end else begin
      bin = '0;
      // ripple digit by digit; digits 2 and 3 only in 16-bit mode
      for (int i = 0; i < DIGITS; i++) begin
        if (wide || i < 2) begin
          s = {1'b0, a[i*DIGIT_W +: DIGIT_W]} + {1'b0, b[i*DIGIT_W +: DIGIT_W]}
              + {4'b0, c};
          if ((wide && i == 3) || (!wide && i == 1)) begin
            top_s = s[3:0];
          end
          if (sub) begin
            c   = s[4];
            adj = s[4] ? {1'b0, s} : ({1'b0, s} - BCD_ADJ);
          end else begin
            adj = (s > BCD_MAX) ? ({1'b0, s} + BCD_ADJ) : {1'b0, s};
            c   = (adj > 6'd15);
          end
          res[i*DIGIT_W +: DIGIT_W] = adj[3:0];
        end
      end
      raw = wide ? {top_s, res[11:0]} : {8'h00, top_s, res[3:0]};
    end
    sign_v = wide ? (~(a[15] ^ b[15]) & (a[15] ^ raw[15]))
                  : (~(a[7] ^ b[7]) & (a[7] ^ raw[7]));
    r.sum  = res;
    r.cout = c;
    r.vout = sign_v;
    return r;
  endfunction

  // ---- handshake: a held result also stalls a full input register ----
  logic in_valid_q, out_valid_q;
  logic out_ready, in_ready;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;

  // ---- input register ----
  logic [IN_DATA_W-1:0] in_data_q;
  logic [IN_USER_W-1:0] in_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  // ---- field decode ----
  op_e               op;
  logic              wide;
  logic [WORD_W-1:0] a, b, b_inv, sign_mask;
  logic              cin, vin, dec;

  assign op        = op_e'(in_user_q[IN_OP_LSB +: 3]);
  assign wide      = in_user_q[IN_WIDE_BIT];
  assign a         = wide ? in_data_q[IN_A_LSB +: WORD_W]
                          : {8'h00, in_data_q[IN_A_LSB +: 8]};
  assign b         = wide ? in_data_q[IN_B_LSB +: WORD_W]
                          : {8'h00, in_data_q[IN_B_LSB +: 8]};
  assign b_inv     = wide ? ~b : {8'h00, ~b[7:0]};
  assign sign_mask = wide ? 16'h8000 : 16'h0080;
  assign cin       = in_data_q[IN_C_BIT];
  assign vin       = in_data_q[IN_V_BIT];
  assign dec       = in_data_q[IN_D_BIT];

  // ---- ALU ----
  add_res_t          add_r;
  logic [WORD_W:0]   cmp_diff;
  logic [WORD_W-1:0] res;
  logic              a_top, cout, vout, zout, nout;

  assign add_r    = add_core(a, (op == OP_SBC) ? b_inv : b, cin, dec,
                             (op == OP_SBC), wide);
  assign cmp_diff = {1'b0, a} - {1'b0, b};
  assign a_top    = wide ? a[15] : a[7];

  always_comb begin
    res  = '0;
    cout = cin;
    vout = vin;
    case (op)
      OP_ASL: begin
        cout = a_top;
        res  = a << 1;
      end
      OP_LSR: begin
        cout = a[0];
        res  = a >> 1;
      end
      OP_ROL: begin
        cout = a_top;
        res  = (a << 1) | {{(WORD_W-1){1'b0}}, cin};
      end
      OP_ROR: begin
        cout = a[0];
        res  = (a >> 1) | (cin ? sign_mask : '0);
      end
      OP_ADC, OP_SBC: begin
        res  = add_r.sum;
        cout = add_r.cout;
        vout = add_r.vout;
      end
      OP_BIT: begin
        res = a & b;
      end
      OP_CMP: begin
        res  = cmp_diff[WORD_W-1:0];
        cout = !cmp_diff[WORD_W];
      end
      default: begin
        res = '0;
      end
    endcase
    if (!wide) begin
      res[15:8] = 8'h00;
    end
  end

  assign zout = (res == '0);
  assign nout = (op != OP_BIT) && ((res & sign_mask) != '0);

  // ---- result register ----
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_data_q <= {4'h0, nout, zout, vout, cout, res};
    end
  end

  assign m_axis_tdata = out_data_q;

endmodule

FILE: sv/alubcd_checker.sv
// ----------------------------------------------------------------------------
// ALU port checker
// Watches the result stream of the ALU and flags inconsistent transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alu_8_16_bit_with_bcd_macros.svh"

module alubcd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [alubcd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import alubcd_pkg::*;

  logic res_zero, z_flag, n_flag;

  assign res_zero = (m_axis_tdata[OUT_RES_LSB +: WORD_W] == '0);
  assign z_flag   = m_axis_tdata[OUT_Z_BIT];
  assign n_flag   = m_axis_tdata[OUT_N_BIT];

  // the first edge in reset may still see the valid flag unset by reset
  `ALUBCD_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid during reset")
  `ALUBCD_ASSERT(a_valid_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `ALUBCD_ASSERT(a_data_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
  `ALUBCD_ASSERT(a_zero_match, clk_i, rst_ni, m_axis_tvalid |-> (z_flag == res_zero), "zero flag disagrees with result")
  `ALUBCD_ASSERT(a_n_z_excl, clk_i, rst_ni, m_axis_tvalid |-> !(z_flag && n_flag), "negative and zero both set")

endmodule

bind alu_8_16_bit_with_bcd alubcd_checker u_alubcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/alu_8_16_bit_with_bcd_tb.sv
// ----------------------------------------------------------------------------
// ALU stream testbench
// Sends operations through the slave stream and predicts each result with a
// behavioral ALU: shifts, rotates, binary and BCD add/subtract, BIT and CMP.
// Results on the master stream are checked field by field in order. Both
// sides get random idle gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alu_8_16_bit_with_bcd_tb;
  import alubcd_pkg::*;

  localparam int unsigned RANDOM_OPS   = 1500;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 10;    // result lags its operation through both DUT registers
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic [15:0] CORNER_VALS [9] = '{
    16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0080,
    16'h007F, 16'h0001, 16'h9999, 16'h0099
  };

  typedef struct {
    op_e         op;
    logic        wide;
    logic [15:0] a;
    logic [15:0] b;
    logic        cin;
    logic        vin;
    logic        dec;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] res;
    logic        c;
    logic        v;
    logic        z;
    logic        n;
  } alu_out_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  alu_req_t    op_queue[$];
  alu_out_t    alu_results_q[$];
  alu_req_t    drv_req;

  int unsigned total_ops;
  int unsigned sent_count     = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned err_count      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned op_hits [8];
  int unsigned bcd_ops        = 0;
  int unsigned wide_ops       = 0;

  alu_8_16_bit_with_bcd dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Behavioral ALU: result and flags for one operation.
  function automatic alu_out_t alu_compute(alu_req_t r);
    int unsigned bits, msk, sgn, a, b, c, s, adj, sum, raw, nd, sh, i;
    alu_out_t    o;
    bits = r.wide ? 16 : 8;
    msk  = r.wide ? 32'hFFFF : 32'hFF;
    sgn  = r.wide ? 32'h8000 : 32'h80;
    a    = r.a & msk;
    b    = r.b & msk;
    c    = r.cin;
    sum  = 0;
    raw  = 0;
    o.c  = r.cin;
    o.v  = r.vin;
    case (r.op)
      OP_ASL: begin
        o.c = (a & sgn) != 0;
        sum = (a << 1) & msk;
      end
      OP_LSR: begin
        o.c = a[0];
        sum = a >> 1;
      end
      OP_ROL: begin
        o.c = (a & sgn) != 0;
        sum = ((a << 1) | r.cin) & msk;
      end
      OP_ROR: begin
        o.c = a[0];
        sum = (a >> 1) | (r.cin ? sgn : 0);
      end
      OP_ADC, OP_SBC: begin
        if (r.op == OP_SBC) b = ~b & msk;
        if (!r.dec) begin
          s   = a + b + c;
          c   = (s >> bits) & 1;
          sum = s & msk;
          raw = sum;
        end else begin
          // digit-serial BCD; V looks at the top digit before correction
          nd = bits / 4;
          for (i = 0; i < nd; i++) begin
            sh  = 4 * i;
            s   = ((a >> sh) & 32'hF) + ((b >> sh) & 32'hF) + c;
            adj = s;
            if (i + 1 == nd) raw = sum | ((s & 32'hF) << sh);
            if (r.op == OP_SBC) begin
              c = (s > 15);
              if (s <= 15) adj = (s - 6) & 32'hF;
            end else begin
              if (s > 9) adj = s + 6;
              c = (adj > 15);
            end
            sum |= (adj & 32'hF) << sh;
          end
        end
        o.c = c[0];
        o.v = ((~(a ^ b) & (a ^ raw) & sgn) != 0);
      end
      OP_BIT: sum = a & b;
      default: begin
        sum = (a - b) & msk;
        o.c = (a >= b);
      end
    endcase
    sum  &= msk;
    o.res = sum[15:0];
    o.z   = (sum == 0);
    o.n   = (r.op == OP_BIT) ? 1'b0 : ((sum & sgn) != 0);
    return o;
  endfunction

  // Mostly short gaps, a few long ones; every fourth run of 128 transfers
  // goes without idling.
  function automatic int unsigned pick_gap(int unsigned n);
    int unsigned r;
    if ((n / 128) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    int unsigned k, i;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      v = 16'($urandom_range(0, 16'hFFFF));
    end else if (k < 75) begin
      for (i = 0; i < 4; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    end else begin
      v = CORNER_VALS[$urandom_range(0, 8)];
    end
    return v;
  endfunction

  task automatic queue_op(op_e op, logic wide, logic [15:0] a, logic [15:0] b,
                          logic cin, logic vin, logic dec);
    alu_req_t r;
    r = '{op: op, wide: wide, a: a, b: b, cin: cin, vin: vin, dec: dec};
    op_queue.push_back(r);
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("%t ERROR %s", $realtime, msg);
  endtask

  // Slave-side driver: hold the current transfer until taken, then idle or
  // present the next operation.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && accepted_count != sent_count)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          drv_req = op_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, drv_req.dec, drv_req.vin, drv_req.cin,
                            drv_req.b, drv_req.a};
          s_axis_tuser  <= {drv_req.wide, drv_req.op};
          sent_count++;
          send_gap = pick_gap(sent_count);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Master-side backpressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(checked_count + 64);
      end
    end
  end

  // Monitor: predict on slave transfers, check master transfers, watchdog.
  always @(posedge clk_i) begin
    alu_out_t got, want;
    if (rst_ni) begin
      quiet_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        alu_results_q.push_back(alu_compute(drv_req));
        accepted_count++;
        quiet_cycles = 0;
        op_hits[drv_req.op]++;
        if (drv_req.dec && (drv_req.op == OP_ADC || drv_req.op == OP_SBC)) bcd_ops++;
        if (drv_req.wide) wide_ops++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got.res = m_axis_tdata[OUT_RES_LSB +: WORD_W];
        got.c   = m_axis_tdata[OUT_C_BIT];
        got.v   = m_axis_tdata[OUT_V_BIT];
        got.z   = m_axis_tdata[OUT_Z_BIT];
        got.n   = m_axis_tdata[OUT_N_BIT];
        if (alu_results_q.size() == 0) begin
          note_error($sformatf("result with nothing pending: res=%h c%0b v%0b z%0b n%0b",
                               got.res, got.c, got.v, got.z, got.n));
        end else begin
          want = alu_results_q.pop_front();
          checked_count++;
          if (got.res !== want.res || got.c !== want.c || got.v !== want.v ||
              got.z !== want.z || got.n !== want.n)
            note_error($sformatf(
              "result %0d: exp res=%h c%0b v%0b z%0b n%0b, got res=%h c%0b v%0b z%0b n%0b",
              checked_count, want.res, want.c, want.v, want.z, want.n,
              got.res, got.c, got.v, got.z, got.n));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d of %0d operations taken, %0d results pending",
                 accepted_count, total_ops, alu_results_q.size());
        $display("alu_8_16_bit_with_bcd_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    alu_req_t    r;

    // directed corners: shifts out of both ends, upper bytes ignored in
    // 8-bit mode, overflow and carry edges, BCD wrap, non-BCD digits
    queue_op(OP_ASL, 1'b0, 16'h0080, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_op(OP_ASL, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    queue_op(OP_LSR, 1'b0, 16'hAB01, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_op(OP_LSR, 1'b1, 16'h8000, 16'h0000, 1'b1, 1'b0, 1'b0);
    queue_op(OP_ROL, 1'b0, 16'h0080, 16'h0000, 1'b1, 1'b0, 1'b0);
    queue_op(OP_ROR, 1'b1, 16'h0001, 16'h0000, 1'b1, 1'b1, 1'b0);
    queue_op(OP_ROR, 1'b0, 16'hFF00, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    queue_op(OP_ADC, 1'b0, 16'h007F, 16'h0001, 1'b0, 1'b0, 1'b0);
    queue_op(OP_ADC, 1'b1, 16'hFFFF, 16'h0001, 1'b0, 1'b1, 1'b0);
    queue_op(OP_ADC, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0);
    queue_op(OP_ADC, 1'b0, 16'h0099, 16'h0001, 1'b0, 1'b0, 1'b1);
    queue_op(OP_ADC, 1'b1, 16'h9999, 16'h0000, 1'b1, 1'b0, 1'b1);
    queue_op(OP_ADC, 1'b0, 16'h12FF, 16'h34FF, 1'b1, 1'b0, 1'b1);
    queue_op(OP_ADC, 1'b0, 16'h0079, 16'h0000, 1'b1, 1'b0, 1'b1);
    queue_op(OP_SBC, 1'b0, 16'h0000, 16'h0001, 1'b1, 1'b0, 1'b0);
    queue_op(OP_SBC, 1'b1, 16'h8000, 16'h0001, 1'b1, 1'b0, 1'b0);
    queue_op(OP_SBC, 1'b0, 16'h0000, 16'h0001, 1'b1, 1'b1, 1'b1);
    queue_op(OP_SBC, 1'b1, 16'h1000, 16'h0001, 1'b1, 1'b0, 1'b1);
    queue_op(OP_SBC, 1'b1, 16'hABCD, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    queue_op(OP_BIT, 1'b0, 16'h00F0, 16'h000F, 1'b0, 1'b0, 1'b0);
    queue_op(OP_BIT, 1'b1, 16'hFFFF, 16'h8000, 1'b1, 1'b1, 1'b1);
    queue_op(OP_CMP, 1'b0, 16'h0010, 16'h0020, 1'b1, 1'b0, 1'b0);
    queue_op(OP_CMP, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    queue_op(OP_CMP, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0);

    for (k = 0; k < RANDOM_OPS; k++) begin
      r.op   = op_e'($urandom_range(0, 7));
      r.wide = 1'($urandom_range(0, 1));
      r.a    = pick_operand();
      r.b    = pick_operand();
      r.cin  = 1'($urandom_range(0, 1));
      r.vin  = 1'($urandom_range(0, 1));
      // lean decimal mode onto the add/subtract ops
      if (r.op == OP_ADC || r.op == OP_SBC) r.dec = ($urandom_range(0, 9) < 6);
      else                                  r.dec = 1'($urandom_range(0, 1));
      op_queue.push_back(r);
    end
    total_ops = op_queue.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (accepted_count < total_ops || alu_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d results checked; asl %0d lsr %0d rol %0d ror %0d adc %0d sbc %0d bit %0d cmp %0d",
             checked_count, op_hits[OP_ASL], op_hits[OP_LSR], op_hits[OP_ROL],
             op_hits[OP_ROR], op_hits[OP_ADC], op_hits[OP_SBC], op_hits[OP_BIT],
             op_hits[OP_CMP]);
    $display("%0d BCD add/subtract, %0d in 16-bit mode, %0d failures",
             bcd_ops, wide_ops, err_count);
    if (err_count == 0) begin
      $display("alu_8_16_bit_with_bcd_tb: clean");
    end else begin
      $display("alu_8_16_bit_with_bcd_tb: errors");
    end
    $finish;
  end

endmodule
